/* rtl/murmur2_hash32_defines.svh */
// Assertion macros for the MurmurHash2 hasher RTL.
`ifndef MURMUR2_HASH32_DEFINES_SVH
`define MURMUR2_HASH32_DEFINES_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same-cycle implication violated");

`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle implication violated");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)

`define ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

/* rtl/mh2_pkg.sv */
// Types, constants and helpers for the MurmurHash2 hasher.
`timescale 1ns / 1ps

package mh2_pkg;

    localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
    localparam int unsigned MIX_SHIFT   = 24;
    localparam int unsigned FIN_SHIFT_A = 13;
    localparam int unsigned FIN_SHIFT_B = 15;

    localparam logic [2:0]  FULL_BYTES  = 3'd4;
    localparam logic [2:0]  NO_BYTES    = 3'd0;

    localparam int unsigned CFG_ADDR_W  = 3;
    localparam logic        REG_SEED    = 1'b0;

    typedef struct packed {
        logic [31:0] k_mix;
        logic [31:0] tail_data;
        logic [2:0]  count;
        logic [31:0] msg_len;
        logic        first;
        logic        last;
        logic        chain;
    } mh2_op_t;

    typedef enum logic [1:0] {
        BK_MIX,
        BK_FIN_MUL,
        BK_FIN_OUT
    } mh2_bk_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } mh2_q_stat_t;

    typedef struct packed {
        logic pop;
        logic fin_busy;
        logic commit;
    } mh2_bk_stat_t;

    function automatic logic [31:0] mul_lo(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        begin
            p = {32'd0, a} * {32'd0, b};
            return p[31:0];
        end
    endfunction

    function automatic logic [31:0] tail_mask(input logic [2:0] count);
        logic [31:0] m;
        begin
            unique case (count)
                3'd1:    m = 32'h0000_00ff;
                3'd2:    m = 32'h0000_ffff;
                3'd3:    m = 32'h00ff_ffff;
                default: m = 32'hffff_ffff;
            endcase
            return m;
        end
    endfunction

endpackage

/* rtl/mh2_if.sv */
// Handshake channel interfaces for message words and hash results.
`timescale 1ns / 1ps

interface mh2_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic [31:0] message_length;
    logic        first_word;
    logic        last_word;
    logic        chain_previous;

    modport source (
        output valid, data_word, byte_count, message_length,
               first_word, last_word, chain_previous,
        input  ready
    );
    modport sink (
        input  valid, data_word, byte_count, message_length,
               first_word, last_word, chain_previous,
        output ready
    );
endinterface

interface mh2_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;
    logic        length_mismatch;

    modport source (
        output valid, hash_value, length_mismatch,
        input  ready
    );
    modport sink (
        input  valid, hash_value, length_mismatch,
        output ready
    );
endinterface

/* rtl/murmur2_hash32.sv */
// Top level of the streaming 32-bit MurmurHash2 hasher with APB seed register.
// The front end takes one word per cycle while the queue has room and premixes full-word
// keys through two registered 32x32 multiplies into a QUEUE_DEPTH-entry queue. The hash
// engine retires one word per cycle with its single multiplier while the queue is not empty;
// a last word then steps through mix, finalize multiply and result register, and a word
// passes the s1 and s2 front-end registers and the queue on its way to the engine.
// The result sits in an output register while the next message streams in; a new
// final word waits only if that register has not been taken. seed_value lies at byte
// address 0 and is sampled when a first word reaches the engine.
`timescale 1ns / 1ps
`include "murmur2_hash32_defines.svh"

module murmur2_hash32 #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                             clk,
    input  logic                             rst_n,
    mh2_in_if.sink                           in_ch,
    mh2_out_if.source                        out_ch,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mh2_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    logic [31:0]           seed_reg;
    logic [31:0]           seed_next;
    logic                  cfg_wr;
    logic                  push;
    mh2_pkg::mh2_op_t      push_op;
    mh2_pkg::mh2_op_t      head_op;
    mh2_pkg::mh2_q_stat_t  q_stat;
    mh2_pkg::mh2_bk_stat_t bk_stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == mh2_pkg::REG_SEED) ? seed_reg : 32'd0;

    always_comb
    begin
        seed_next = seed_reg;
        if (cfg_wr && (paddr[2] == mh2_pkg::REG_SEED))
        begin
            seed_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else
        begin
            seed_reg <= seed_next;
        end
    end

    mh2_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_full  (q_stat.full),
        .push    (push),
        .push_op (push_op)
    );

    mh2_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (bk_stat.pop),
        .head_op (head_op),
        .stat    (q_stat)
    );

    mh2_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_value (seed_reg),
        .head_op    (head_op),
        .q_stat     (q_stat),
        .out_ch     (out_ch),
        .stat       (bk_stat)
    );

    `ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push, !q_stat.full)
    `ASSERT_IMPLIES(a_no_underflow, clk, rst_n, bk_stat.pop, !q_stat.empty)
    `ASSERT_IMPLIES(a_fin_holds_queue, clk, rst_n, bk_stat.fin_busy, !bk_stat.pop)
    `ASSERT_NEXT(a_commit_shows, clk, rst_n, bk_stat.commit, out_ch.valid)

endmodule

/* rtl/mh2_front.sv */
// Front end: accepts words, classifies byte counts and premixes full-word keys.
`timescale 1ns / 1ps

module mh2_front (
    input  logic            clk,
    input  logic            rst_n,
    mh2_in_if.sink          in_ch,
    input  logic            q_full,
    output logic            push,
    output mh2_pkg::mh2_op_t push_op
);

    logic             s1_v_reg;
    logic             s1_v_next;
    logic [31:0]      s1_k_reg;
    logic [31:0]      s1_tail_reg;
    logic [2:0]       s1_count_reg;
    logic [31:0]      s1_len_reg;
    logic             s1_first_reg;
    logic             s1_last_reg;
    logic             s1_chain_reg;

    logic             s2_v_reg;
    logic             s2_v_next;
    mh2_pkg::mh2_op_t s2_op_reg;

    logic             s1_ready;
    logic             s2_ready;
    logic             take;
    logic [2:0]       count_clamped;
    logic [31:0]      k_fold;

    assign s2_ready    = !s2_v_reg || !q_full;
    assign s1_ready    = !s1_v_reg || s2_ready;
    assign in_ch.ready = s1_ready;
    assign take        = in_ch.valid && s1_ready;
    assign push        = s2_v_reg && !q_full;
    assign push_op     = s2_op_reg;

    assign count_clamped = (in_ch.byte_count > mh2_pkg::FULL_BYTES) ?
                           mh2_pkg::FULL_BYTES : in_ch.byte_count;
    assign k_fold        = s1_k_reg ^ (s1_k_reg >> mh2_pkg::MIX_SHIFT);

    always_comb
    begin
        s1_v_next = s1_v_reg;
        if (s1_ready)
        begin
            s1_v_next = in_ch.valid;
        end
        s2_v_next = s2_v_reg;
        if (s2_ready)
        begin
            s2_v_next = s1_v_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= s1_v_next;
            s2_v_reg <= s2_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_k_reg     <= mh2_pkg::mul_lo(in_ch.data_word, mh2_pkg::MIX_MUL);
            s1_tail_reg  <= in_ch.data_word & mh2_pkg::tail_mask(count_clamped);
            s1_count_reg <= count_clamped;
            s1_len_reg   <= in_ch.message_length;
            s1_first_reg <= in_ch.first_word;
            s1_last_reg  <= in_ch.last_word;
            s1_chain_reg <= in_ch.chain_previous;
        end
        if (s2_ready && s1_v_reg)
        begin
            s2_op_reg.k_mix     <= mh2_pkg::mul_lo(k_fold, mh2_pkg::MIX_MUL);
            s2_op_reg.tail_data <= s1_tail_reg;
            s2_op_reg.count     <= s1_count_reg;
            s2_op_reg.msg_len   <= s1_len_reg;
            s2_op_reg.first     <= s1_first_reg;
            s2_op_reg.last      <= s1_last_reg;
            s2_op_reg.chain     <= s1_chain_reg;
        end
    end

endmodule

/* rtl/mh2_queue.sv */
// Small FIFO that decouples the front end from the hash engine.
`timescale 1ns / 1ps

module mh2_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  mh2_pkg::mh2_op_t      push_op,
    input  logic                  pop,
    output mh2_pkg::mh2_op_t      head_op,
    output mh2_pkg::mh2_q_stat_t  stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    mh2_pkg::mh2_op_t store [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign stat.full  = (cnt_reg == FULL_CNT);
    assign stat.empty = (cnt_reg == '0);
    assign head_op    = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_op;
        end
    end

endmodule

/* rtl/mh2_back.sv */
// Hash engine: folds words into the running hash, finalizes and emits results.
`timescale 1ns / 1ps

module mh2_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [31:0]           seed_value,
    input  mh2_pkg::mh2_op_t      head_op,
    input  mh2_pkg::mh2_q_stat_t  q_stat,
    mh2_out_if.source             out_ch,
    output mh2_pkg::mh2_bk_stat_t stat
);

    mh2_pkg::mh2_bk_state_t state_reg;
    mh2_pkg::mh2_bk_state_t state_next;

    logic [31:0] run_hash_reg;
    logic [31:0] run_hash_next;
    logic [31:0] byte_cnt_reg;
    logic [31:0] byte_cnt_next;
    logic [31:0] decl_len_reg;
    logic [31:0] decl_len_next;
    logic [31:0] prev_hash_reg;
    logic [31:0] prev_hash_next;
    logic        out_v_reg;
    logic        out_v_next;

    logic [31:0] fin_prod_reg;
    logic [31:0] fin_prod_next;
    logic        mismatch_reg;
    logic        mismatch_next;
    logic [31:0] out_hash_reg;
    logic [31:0] out_hash_next;
    logic        out_mis_reg;
    logic        out_mis_next;

    logic [31:0] h0;
    logic [31:0] cnt_base;
    logic [31:0] len_base;
    logic [31:0] cnt_sum;
    logic [31:0] mul_a;
    logic [31:0] mul_p;
    logic [31:0] h_new;
    logic [31:0] fin_fold;
    logic [31:0] fin_hash;
    logic        pop;
    logic        commit;

    assign h0       = head_op.first ?
                      ((head_op.chain ? prev_hash_reg : seed_value) ^ head_op.msg_len) :
                      run_hash_reg;
    assign cnt_base = head_op.first ? 32'd0 : byte_cnt_reg;
    assign len_base = head_op.first ? head_op.msg_len : decl_len_reg;
    assign cnt_sum  = cnt_base + {29'd0, head_op.count};
    assign fin_fold = run_hash_reg ^ (run_hash_reg >> mh2_pkg::FIN_SHIFT_A);
    assign fin_hash = fin_prod_reg ^ (fin_prod_reg >> mh2_pkg::FIN_SHIFT_B);
    assign mul_p    = mh2_pkg::mul_lo(mul_a, mh2_pkg::MIX_MUL);

    always_comb
    begin
        if (state_reg == mh2_pkg::BK_MIX)
        begin
            mul_a = (head_op.count == mh2_pkg::FULL_BYTES) ? h0 : (h0 ^ head_op.tail_data);
        end
        else
        begin
            mul_a = fin_fold;
        end
        if (head_op.count == mh2_pkg::FULL_BYTES)
        begin
            h_new = mul_p ^ head_op.k_mix;
        end
        else if (head_op.count == mh2_pkg::NO_BYTES)
        begin
            h_new = h0;
        end
        else
        begin
            h_new = mul_p;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        run_hash_next  = run_hash_reg;
        byte_cnt_next  = byte_cnt_reg;
        decl_len_next  = decl_len_reg;
        prev_hash_next = prev_hash_reg;
        fin_prod_next  = fin_prod_reg;
        mismatch_next  = mismatch_reg;
        out_hash_next  = out_hash_reg;
        out_mis_next   = out_mis_reg;
        out_v_next     = out_v_reg && !out_ch.ready;
        pop            = 1'b0;
        commit         = 1'b0;
        unique case (state_reg)
            mh2_pkg::BK_MIX:
            begin
                if (!q_stat.empty)
                begin
                    pop           = 1'b1;
                    run_hash_next = h_new;
                    byte_cnt_next = cnt_sum;
                    decl_len_next = len_base;
                    mismatch_next = (cnt_sum != len_base);
                    if (head_op.last)
                    begin
                        state_next = mh2_pkg::BK_FIN_MUL;
                    end
                end
            end
            mh2_pkg::BK_FIN_MUL:
            begin
                fin_prod_next = mul_p;
                state_next    = mh2_pkg::BK_FIN_OUT;
            end
            mh2_pkg::BK_FIN_OUT:
            begin
                if (!out_v_reg || out_ch.ready)
                begin
                    commit         = 1'b1;
                    out_v_next     = 1'b1;
                    out_hash_next  = fin_hash;
                    out_mis_next   = mismatch_reg;
                    prev_hash_next = fin_hash;
                    state_next     = mh2_pkg::BK_MIX;
                end
            end
            default:
            begin
                state_next = mh2_pkg::BK_MIX;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mh2_pkg::BK_MIX;
            run_hash_reg  <= '0;
            byte_cnt_reg  <= '0;
            decl_len_reg  <= '0;
            prev_hash_reg <= '0;
            out_v_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_hash_reg  <= run_hash_next;
            byte_cnt_reg  <= byte_cnt_next;
            decl_len_reg  <= decl_len_next;
            prev_hash_reg <= prev_hash_next;
            out_v_reg     <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fin_prod_reg <= fin_prod_next;
        mismatch_reg <= mismatch_next;
        out_hash_reg <= out_hash_next;
        out_mis_reg  <= out_mis_next;
    end

    assign out_ch.valid           = out_v_reg;
    assign out_ch.hash_value      = out_hash_reg;
    assign out_ch.length_mismatch = out_mis_reg;

    assign stat.pop      = pop;
    assign stat.fin_busy = (state_reg != mh2_pkg::BK_MIX);
    assign stat.commit   = commit;

endmodule

/* tb/sv/murmur2_hash32_checker.sv */
// Checker for the MurmurHash2 hasher: predicts each hash result and compares it.
`timescale 1ns / 1ps

module murmur2_hash32_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    mh2_in_if                              in_ch,
    mh2_out_if                             out_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [mh2_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output int                             fail_count,
    output int                             pending
);

    typedef struct packed {
        logic [31:0] hash;
        logic        mismatch;
    } digest_t;

    digest_t     expected_digests[$];
    logic [31:0] seed_reg;
    logic [31:0] run_hash;
    logic [31:0] bytes_seen;
    logic [31:0] bytes_declared;
    logic [31:0] last_digest;
    int          mismatches;

    function automatic logic [31:0] times_m(input logic [31:0] x);
        return x * mh2_pkg::MIX_MUL;
    endfunction

    function automatic void absorb_word(input logic [31:0] data, input logic [2:0] cnt_in,
                                        input logic [31:0] len, input logic is_first,
                                        input logic is_last, input logic chain);
        logic [2:0]  cnt;
        logic [31:0] k;
        logic [31:0] h;
        digest_t     d;
        cnt = (cnt_in > mh2_pkg::FULL_BYTES) ? mh2_pkg::FULL_BYTES : cnt_in;
        if (is_first)
        begin
            run_hash       = (chain ? last_digest : seed_reg) ^ len;
            bytes_seen     = '0;
            bytes_declared = len;
        end
        h = run_hash;
        if (cnt == mh2_pkg::FULL_BYTES)
        begin
            k = times_m(data);
            k = k ^ (k >> mh2_pkg::MIX_SHIFT);
            k = times_m(k);
            h = times_m(h) ^ k;
        end
        else if (cnt != mh2_pkg::NO_BYTES)
        begin
            h = h ^ (data & ((32'h1 << (8 * cnt)) - 32'h1));
            h = times_m(h);
        end
        run_hash   = h;
        bytes_seen = bytes_seen + 32'(cnt);
        if (is_last)
        begin
            h           = h ^ (h >> mh2_pkg::FIN_SHIFT_A);
            h           = times_m(h);
            h           = h ^ (h >> mh2_pkg::FIN_SHIFT_B);
            last_digest = h;
            d.hash      = h;
            d.mismatch  = (bytes_seen != bytes_declared);
            expected_digests.push_back(d);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        digest_t want_d;
        if (!rst_n)
        begin
            seed_reg       = '0;
            run_hash       = '0;
            bytes_seen     = '0;
            bytes_declared = '0;
            last_digest    = '0;
            mismatches     = 0;
            expected_digests.delete();
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_digests.size() == 0)
                    report_mismatch("hash with none expected", out_ch.hash_value, '0);
                else
                begin
                    want_d = expected_digests.pop_front();
                    if (out_ch.hash_value !== want_d.hash)
                        report_mismatch("hash_value", out_ch.hash_value, want_d.hash);
                    if (out_ch.length_mismatch !== want_d.mismatch)
                        report_mismatch("length_mismatch", 32'(out_ch.length_mismatch),
                                        32'(want_d.mismatch));
                end
            end
            if (in_ch.valid && in_ch.ready)
                absorb_word(in_ch.data_word, in_ch.byte_count, in_ch.message_length,
                            in_ch.first_word, in_ch.last_word, in_ch.chain_previous);
            if (psel && penable && pwrite && pready &&
                paddr[mh2_pkg::CFG_ADDR_W-1:2] == mh2_pkg::REG_SEED)
                seed_reg = pwdata;
        end
        pending    <= expected_digests.size();
        fail_count <= mismatches;
    end

endmodule

/* tb/sv/tb_murmur2_hash32.sv */
// Testbench top for the MurmurHash2 hasher: reset, seed writes, word stimulus, verdict.
`timescale 1ns / 1ps

module tb_murmur2_hash32;

    localparam logic [mh2_pkg::CFG_ADDR_W-1:0] SEED_ADDR  = {mh2_pkg::REG_SEED, 2'b00};
    localparam logic [mh2_pkg::CFG_ADDR_W-1:0] SPARE_ADDR = 3'd4;
    localparam int PHASE_WORDS   = 340;
    localparam int SETTLE_CYCLES = 32;

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [mh2_pkg::CFG_ADDR_W-1:0] paddr;
    logic [31:0]                    pwdata;
    logic [31:0]                    prdata;
    logic                           pready;
    int                             fail_count;
    int                             pending;
    int                             words_sent;
    int                             tx_idle_pct;
    int                             rx_idle_pct;

    mh2_in_if  in_ch ();
    mh2_out_if out_ch ();

    murmur2_hash32 uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    murmur2_hash32_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    always @(posedge clk)
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);

    task automatic push_word(input logic [31:0] data, input logic [2:0] cnt,
                             input logic [31:0] len, input logic is_first,
                             input logic is_last, input logic chain);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.data_word      <= data;
        in_ch.byte_count     <= cnt;
        in_ch.message_length <= len;
        in_ch.first_word     <= is_first;
        in_ch.last_word      <= is_last;
        in_ch.chain_previous <= chain;
        do @(posedge clk); while (!in_ch.ready);
        words_sent++;
    endtask

    task automatic send_message();
        int unsigned n_words;
        int unsigned tail;
        int unsigned total;
        logic [31:0] declared;
        logic        chain;
        logic [2:0]  cnt;
        n_words  = ($urandom_range(9) == 0) ? $urandom_range(20, 7) : $urandom_range(6, 1);
        tail     = $urandom_range(4, (n_words == 1) ? 0 : 1);
        total    = 4 * (n_words - 1) + tail;
        declared = ($urandom_range(7) == 0) ? $urandom : total;
        chain    = $urandom_range(1);
        for (int unsigned i = 0; i < n_words; i++)
        begin
            if (i == n_words - 1)
                cnt = 3'(tail);
            else
                cnt = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) :
                      mh2_pkg::FULL_BYTES;
            push_word($urandom, cnt, (i == 0) ? declared : $urandom, i == 0,
                      i == n_words - 1, (i == 0) ? chain : 1'($urandom_range(1)));
        end
    endtask

    task automatic run_phase(input int n_words);
        int target;
        target = words_sent + n_words;
        while (words_sent < target)
        begin
            if ($urandom_range(99) < 12)
                push_word($urandom, 3'($urandom_range(7)), $urandom, 1'($urandom_range(1)),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
            else
                send_message();
        end
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [mh2_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b1;
        paddr                = '0;
        pwdata               = '0;
        in_ch.valid          = 1'b0;
        in_ch.data_word      = '0;
        in_ch.byte_count     = mh2_pkg::NO_BYTES;
        in_ch.message_length = '0;
        in_ch.first_word     = 1'b0;
        in_ch.last_word      = 1'b0;
        in_ch.chain_previous = 1'b0;
        out_ch.ready         = 1'b0;
        words_sent           = 0;
        tx_idle_pct          = 14;
        rx_idle_pct          = 60;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // continue from reset state without a message start
        push_word(32'hFFFF_FFFF, mh2_pkg::FULL_BYTES, 32'h0, 1'b0, 1'b1, 1'b0);
        push_word(32'h0000_0000, mh2_pkg::NO_BYTES, 32'h0, 1'b1, 1'b1, 1'b0);
        push_word(32'hFFFF_FFFF, mh2_pkg::FULL_BYTES, 32'd4, 1'b1, 1'b1, 1'b1);
        push_word(32'hA5C3_5A3C, 3'd1, 32'd1, 1'b1, 1'b1, 1'b0);
        push_word(32'hA5C3_5A3C, 3'd2, 32'd2, 1'b1, 1'b1, 1'b0);
        push_word(32'hA5C3_5A3C, 3'd3, 32'd3, 1'b1, 1'b1, 1'b1);
        push_word(32'h1234_5678, 3'd5, 32'd4, 1'b1, 1'b1, 1'b0);
        push_word(32'h8765_4321, 3'd6, 32'd4, 1'b1, 1'b1, 1'b0);
        push_word(32'hFFFF_0000, 3'd7, 32'd4, 1'b1, 1'b1, 1'b0);
        // short word mid-message, chain set on the first word, declared length wrong
        push_word(32'h0123_4567, mh2_pkg::FULL_BYTES, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1);
        push_word(32'h89AB_CDEF, 3'd2, 32'h0, 1'b0, 1'b0, 1'b0);
        push_word(32'hDEAD_BEEF, mh2_pkg::FULL_BYTES, 32'h5555_AAAA, 1'b0, 1'b0, 1'b1);
        push_word(32'h00C0_FFEE, 3'd3, 32'h0, 1'b0, 1'b1, 1'b0);
        // continue from the previous message state
        push_word(32'h0000_0001, mh2_pkg::FULL_BYTES, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1);
        push_word(32'h8000_0000, mh2_pkg::NO_BYTES, 32'h0, 1'b0, 1'b1, 1'b0);
        push_word(32'hCAFE_F00D, mh2_pkg::FULL_BYTES, 32'd8, 1'b1, 1'b0, 1'b0);
        push_word(32'h7FFF_FFFF, mh2_pkg::FULL_BYTES, 32'd0, 1'b0, 1'b1, 1'b1);
        push_word(32'hFFFF_FFFF, mh2_pkg::FULL_BYTES, 32'd4, 1'b1, 1'b0, 1'b0);
        push_word(32'hFFFF_FFFF, mh2_pkg::NO_BYTES, 32'd4, 1'b0, 1'b1, 1'b0);
        push_word(32'h0000_0000, mh2_pkg::FULL_BYTES, 32'h0, 1'b1, 1'b1, 1'b1);
        settle();

        write_reg(SEED_ADDR, 32'hFFFF_FFFF);
        write_reg(SPARE_ADDR, $urandom);
        run_phase(PHASE_WORDS);
        settle();

        tx_idle_pct = 60;
        rx_idle_pct = 14;
        write_reg(SEED_ADDR, 32'h0000_0000);
        run_phase(PHASE_WORDS);
        settle();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_reg(SEED_ADDR, $urandom);
        run_phase(PHASE_WORDS);
        settle();

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
